### hw/rtl/mvts_pkg.sv
// ----------------------------------------------------------------------------
// mvts_pkg
// Shared types, codes and constants of the mixing valve dissolved-solids stepper.
// ----------------------------------------------------------------------------
package mvts_pkg;

    localparam int NUM_OUTLETS_DEF  = 8;
    localparam int SETTLE_TICKS_DEF = 5;

    localparam int CMD_W      = 2;
    localparam int SAMPLE_W   = 12;
    localparam int OID_W      = 3;
    localparam int PULSE_W    = 12;
    localparam int TDS_W      = 12;
    localparam int ANGLE_W    = 7;
    localparam int TARGET_W   = 10;
    localparam int TOL_W      = 8;
    localparam int ACCUM_W    = 15;
    localparam int SETTLE_W   = 3;
    localparam int UNIT_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 2;
    localparam int DIV_STEPS  = PULSE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_OUTLET  = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_RAW     = 2'd3
    } t_cmd_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET = 2'd0,
        REG_TOL    = 2'd1,
        REG_PMIN   = 2'd2,
        REG_PMAX   = 2'd3
    } t_reg_idx;

    localparam logic [TARGET_W-1:0] TARGET_RST = 10'd100;
    localparam logic [TARGET_W-1:0] MAX_TARGET = 10'd1000;
    localparam logic [TOL_W-1:0]    TOL_RST    = 8'd10;
    localparam logic [PULSE_W-1:0]  PMIN_RST   = 12'd500;
    localparam logic [PULSE_W-1:0]  PMAX_RST   = 12'd2500;

    localparam logic [12:0] STEP_BIG   = 13'd100;
    localparam logic [12:0] STEP_MID   = 13'd50;
    localparam logic [12:0] STEP_SMALL = 13'd20;

    localparam logic [SETTLE_W-1:0] RAW_SAMPLES = 3'd5;
    localparam logic [PULSE_W-1:0]  MAX_ANGLE   = 12'd90;

    // reciprocal multipliers: floor(x/10) = (x*6554)>>16, floor(x/5) = (x*52429)>>18,
    // floor(x/90) = (x*5826)>>19 over the ranges used here
    localparam logic [15:0] RECIP10 = 16'd6554;
    localparam logic [15:0] RECIP5  = 16'd52429;
    localparam logic [12:0] RECIP90 = 13'd5826;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_FIN,
        S_PREP,
        S_UNIT,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic mul;
        logic fin;
        logic prep;
        logic unit;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_stat;

endpackage

### hw/rtl/mvts_ctrl.sv
// ----------------------------------------------------------------------------
// mvts_ctrl
// Sequencer of the stepper: walks one word through update, scaling, angle
// division and output load, and owns the handshakes.
// ----------------------------------------------------------------------------
module mvts_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    input  logic               i_m_ready,
    output logic               o_m_valid,
    output mvts_pkg::t_dp_cmd  o_cmd,
    input  mvts_pkg::t_dp_stat i_stat
);

    mvts_pkg::t_state r_state;
    mvts_pkg::t_state n_state;
    logic             r_m_valid;
    logic             n_m_valid;
    logic             out_free;

    assign out_free = !r_m_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mvts_pkg::S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mvts_pkg::S_IDLE: begin
                if (i_s_valid) begin
                    n_state = mvts_pkg::S_EXEC;
                end
            end
            mvts_pkg::S_EXEC: n_state = mvts_pkg::S_MUL;
            mvts_pkg::S_MUL:  n_state = mvts_pkg::S_FIN;
            mvts_pkg::S_FIN:  n_state = mvts_pkg::S_PREP;
            mvts_pkg::S_PREP: n_state = mvts_pkg::S_UNIT;
            mvts_pkg::S_UNIT: n_state = mvts_pkg::S_DIV;
            mvts_pkg::S_DIV: begin
                if (i_stat.div_last) begin
                    n_state = mvts_pkg::S_DONE;
                end
            end
            mvts_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = mvts_pkg::S_IDLE;
                end
            end
            default: n_state = mvts_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_s_ready      = 1'b0;
        o_cmd.load     = (r_state == mvts_pkg::S_IDLE) && i_s_valid;
        o_s_ready      = (r_state == mvts_pkg::S_IDLE);
        o_cmd.exec     = (r_state == mvts_pkg::S_EXEC);
        o_cmd.mul      = (r_state == mvts_pkg::S_MUL);
        o_cmd.fin      = (r_state == mvts_pkg::S_FIN);
        o_cmd.prep     = (r_state == mvts_pkg::S_PREP);
        o_cmd.unit     = (r_state == mvts_pkg::S_UNIT);
        o_cmd.div_step = (r_state == mvts_pkg::S_DIV);
        o_cmd.out_load = (r_state == mvts_pkg::S_DONE) && out_free;
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (o_cmd.out_load) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end
    end

    assign o_m_valid = r_m_valid;

endmodule

### hw/rtl/mvts_dp.sv
// ----------------------------------------------------------------------------
// mvts_dp
// Datapath of the stepper: configuration and regulation state, shared
// reciprocal multiplier, restoring divider for the steering angle and the
// output word register.
// ----------------------------------------------------------------------------
module mvts_dp #(
    parameter int NUM_OUTLETS  = mvts_pkg::NUM_OUTLETS_DEF,
    parameter int SETTLE_TICKS = mvts_pkg::SETTLE_TICKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mvts_pkg::t_dp_cmd               i_cmd,
    output mvts_pkg::t_dp_stat              o_stat,
    input  logic                            i_cfg_wen,
    input  logic [mvts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mvts_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [mvts_pkg::CMD_W-1:0]      i_in_cmd,
    input  logic [mvts_pkg::SAMPLE_W-1:0]   i_tds_sample,
    input  logic [mvts_pkg::OID_W-1:0]      i_outlet_id,
    input  logic                            i_outlet_open,
    output logic [mvts_pkg::PULSE_W-1:0]    o_pulse_width,
    output logic                            o_power_on,
    output logic                            o_adjusting,
    output logic                            o_report_valid,
    output logic                            o_report_kind,
    output logic [mvts_pkg::TDS_W-1:0]      o_report_tds,
    output logic [mvts_pkg::ANGLE_W-1:0]    o_steering_angle
);

    // configuration
    logic [mvts_pkg::TARGET_W-1:0] r_target;
    logic [mvts_pkg::TOL_W-1:0]    r_tol;
    logic [mvts_pkg::PULSE_W-1:0]  r_pmin;
    logic [mvts_pkg::PULSE_W-1:0]  r_pmax;

    // regulation state
    logic [mvts_pkg::PULSE_W-1:0]  r_pulse;
    logic [NUM_OUTLETS-1:0]        r_mask;
    logic                          r_active;
    logic                          r_raw;
    logic [mvts_pkg::SETTLE_W-1:0] r_settle;
    logic [mvts_pkg::ACCUM_W-1:0]  r_accum;
    logic                          r_power;

    // captured word
    mvts_pkg::t_cmd_code           r_cmd;
    logic [mvts_pkg::SAMPLE_W-1:0] r_sample;
    logic [mvts_pkg::OID_W-1:0]    r_oid;
    logic                          r_oopen;

    // per word scratch
    logic                          r_stepping;
    logic                          r_up;
    logic                          r_neg;
    logic [12:0]                   r_sum;
    logic                          r_raw_rep;
    logic [31:0]                   r_prod;
    logic                          r_rep_valid;
    logic                          r_rep_kind;
    logic [mvts_pkg::TDS_W-1:0]    r_rep_tds;
    logic                          r_inv;
    logic                          r_le;
    logic [mvts_pkg::PULSE_W-1:0]  r_span;
    logic [mvts_pkg::PULSE_W-1:0]  r_num;
    logic [mvts_pkg::UNIT_W-1:0]   r_unit;
    logic [mvts_pkg::PULSE_W-1:0]  r_div_q;
    logic [mvts_pkg::UNIT_W-1:0]   r_div_rem;
    logic [mvts_pkg::DIV_CNT_W-1:0] r_div_cnt;

    // output word
    logic [mvts_pkg::PULSE_W-1:0]  r_o_pulse;
    logic                          r_o_power;
    logic                          r_o_active;
    logic                          r_o_rv;
    logic                          r_o_rk;
    logic [mvts_pkg::TDS_W-1:0]    r_o_rtds;
    logic [mvts_pkg::ANGLE_W-1:0]  r_o_angle;

    // band compare
    logic signed [13:0] s_s, t_s, tol_s, hi1, lo1, hi2, lo2, hi4, lo4;
    logic [12:0]        step;
    logic [12:0]        up_sum;
    logic signed [13:0] down_diff;
    logic               regulate;
    logic [NUM_OUTLETS-1:0] oid_hot;
    logic [mvts_pkg::SETTLE_W-1:0] settle_inc;
    logic [mvts_pkg::ACCUM_W-1:0]  accum_inc;

    // scaling
    logic [15:0] mul_a;
    logic [15:0] mul_c;
    logic [8:0]  quot10;
    logic [12:0] p10;
    logic [mvts_pkg::PULSE_W-1:0] n_pulse_fin;

    // divider
    logic [mvts_pkg::UNIT_W:0]    rem_sh;
    logic                         rem_ge;
    logic [24:0]                  unit_prod;
    logic                         angle_zero;

    assign s_s   = signed'({2'b00, r_sample});
    assign t_s   = signed'({4'b0000, r_target});
    assign tol_s = signed'({6'b000000, r_tol});
    assign hi1   = t_s + tol_s;
    assign lo1   = t_s - tol_s;
    assign hi2   = t_s + (tol_s <<< 1);
    assign lo2   = t_s - (tol_s <<< 1);
    assign hi4   = t_s + (tol_s <<< 2);
    assign lo4   = t_s - (tol_s <<< 2);

    always_comb begin
        if (s_s > hi4 || s_s < lo4) begin
            step = mvts_pkg::STEP_BIG;
        end else if (s_s > hi2 || s_s < lo2) begin
            step = mvts_pkg::STEP_MID;
        end else begin
            step = mvts_pkg::STEP_SMALL;
        end
    end

    assign up_sum     = {1'b0, r_pulse} + step;
    assign down_diff  = signed'({2'b00, r_pulse}) - signed'({1'b0, step});
    assign regulate   = (|r_mask) && r_active;
    assign settle_inc = r_settle + 1'b1;
    assign accum_inc  = r_accum + mvts_pkg::ACCUM_W'(r_sample);

    always_comb begin
        for (int i = 0; i < NUM_OUTLETS; i++) begin
            oid_hot[i] = (r_oid == mvts_pkg::OID_W'(i));
        end
    end

    // shared multiplier operands
    always_comb begin
        if (r_stepping) begin
            mul_a = {3'b000, r_sum};
            mul_c = mvts_pkg::RECIP10;
        end else begin
            mul_a = {1'b0, r_accum};
            mul_c = mvts_pkg::RECIP5;
        end
    end

    assign quot10 = r_prod[24:16];
    assign p10    = {1'b0, quot10, 3'b000} + {3'b000, quot10, 1'b0};

    always_comb begin
        n_pulse_fin = r_pulse;
        if (r_up) begin
            if (p10 > {1'b0, r_pmax}) begin
                n_pulse_fin = r_pmax;
            end else begin
                n_pulse_fin = p10[11:0];
            end
        end else begin
            if (r_neg || p10 < {1'b0, r_pmin}) begin
                n_pulse_fin = r_pmin;
            end else begin
                n_pulse_fin = p10[11:0];
            end
        end
    end

    assign unit_prod  = r_span * mvts_pkg::RECIP90;
    assign rem_sh     = {r_div_rem, r_div_q[mvts_pkg::PULSE_W-1]};
    assign rem_ge     = rem_sh >= {1'b0, r_unit};
    assign angle_zero = r_inv || (r_unit == '0) || r_le;

    assign o_stat.div_last = (r_div_cnt == mvts_pkg::DIV_CNT_W'(mvts_pkg::DIV_STEPS - 1));

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= mvts_pkg::TARGET_RST;
            r_tol       <= mvts_pkg::TOL_RST;
            r_pmin      <= mvts_pkg::PMIN_RST;
            r_pmax      <= mvts_pkg::PMAX_RST;
            r_pulse     <= mvts_pkg::PMAX_RST;
            r_mask      <= '0;
            r_active    <= 1'b1;
            r_raw       <= 1'b0;
            r_settle    <= '0;
            r_accum     <= '0;
            r_power     <= 1'b0;
            r_stepping  <= 1'b0;
            r_raw_rep   <= 1'b0;
            r_rep_valid <= 1'b0;
            r_rep_kind  <= 1'b0;
            r_rep_tds   <= '0;
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    mvts_pkg::REG_TARGET: begin
                        r_target <= (i_cfg_wdata[9:0] > mvts_pkg::MAX_TARGET) ?
                                    mvts_pkg::MAX_TARGET : i_cfg_wdata[9:0];
                        r_active <= 1'b1;
                    end
                    mvts_pkg::REG_TOL:  r_tol  <= i_cfg_wdata[7:0];
                    mvts_pkg::REG_PMIN: r_pmin <= i_cfg_wdata;
                    mvts_pkg::REG_PMAX: r_pmax <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (i_cmd.load) begin
                r_stepping  <= 1'b0;
                r_raw_rep   <= 1'b0;
                r_rep_valid <= 1'b0;
                r_rep_kind  <= 1'b0;
                r_rep_tds   <= '0;
            end

            if (i_cmd.exec) begin
                case (r_cmd)
                    mvts_pkg::CMD_OUTLET: begin
                        r_mask <= r_oopen ? (r_mask | oid_hot) : (r_mask & ~oid_hot);
                    end
                    mvts_pkg::CMD_RESTART: r_active <= 1'b1;
                    mvts_pkg::CMD_RAW: begin
                        r_raw    <= 1'b1;
                        r_accum  <= '0;
                        r_settle <= '0;
                    end
                    default: begin
                        if (regulate) begin
                            r_power <= 1'b1;
                            if (r_raw) begin
                                if (r_pulse > r_pmin) begin
                                    r_pulse <= r_pmin;
                                end
                                r_accum <= accum_inc;
                                if (settle_inc >= mvts_pkg::RAW_SAMPLES) begin
                                    r_raw_rep   <= 1'b1;
                                    r_rep_valid <= 1'b1;
                                    r_rep_kind  <= 1'b0;
                                    r_settle    <= '0;
                                    r_raw       <= 1'b0;
                                end else begin
                                    r_settle <= settle_inc;
                                end
                            end else begin
                                r_accum <= mvts_pkg::ACCUM_W'(r_sample);
                                if (s_s > hi1) begin
                                    r_settle   <= '0;
                                    r_up       <= 1'b1;
                                    r_neg      <= 1'b0;
                                    r_sum      <= up_sum;
                                    r_stepping <= (r_pulse < r_pmax);
                                end else if (s_s < lo1) begin
                                    r_settle   <= '0;
                                    r_up       <= 1'b0;
                                    r_neg      <= down_diff < 0;
                                    r_sum      <= down_diff[12:0];
                                    r_stepping <= (r_pulse > r_pmin);
                                end else if (r_settle >= mvts_pkg::SETTLE_W'(SETTLE_TICKS)) begin
                                    r_rep_valid <= 1'b1;
                                    r_rep_kind  <= 1'b1;
                                    r_rep_tds   <= r_sample;
                                    r_power     <= 1'b0;
                                    r_active    <= 1'b0;
                                    r_settle    <= '0;
                                end else begin
                                    r_settle <= settle_inc;
                                end
                            end
                        end
                    end
                endcase
            end

            if (i_cmd.fin) begin
                if (r_stepping) begin
                    r_pulse <= n_pulse_fin;
                end
                if (r_raw_rep) begin
                    r_rep_tds <= r_prod[29:18];
                end
            end

            if (i_cmd.prep && r_cmd == mvts_pkg::CMD_TICK) begin
                if (!(|r_mask) || !r_active || r_pulse == r_pmax || r_pulse == r_pmin) begin
                    if (!r_raw) begin
                        r_power <= 1'b0;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= mvts_pkg::t_cmd_code'(i_in_cmd);
            r_sample <= i_tds_sample;
            r_oid    <= i_outlet_id;
            r_oopen  <= i_outlet_open;
        end
        if (i_cmd.mul) begin
            r_prod <= mul_a * mul_c;
        end
        if (i_cmd.prep) begin
            r_inv  <= (r_pmax <= r_pmin);
            r_le   <= (r_pulse <= r_pmin);
            r_span <= r_pmax - r_pmin;
            r_num  <= r_pulse - r_pmin;
        end
        if (i_cmd.unit) begin
            r_unit    <= unit_prod[24:19];
            r_div_q   <= r_num;
            r_div_rem <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_rem <= rem_ge ? mvts_pkg::UNIT_W'(rem_sh - {1'b0, r_unit}) :
                                  rem_sh[mvts_pkg::UNIT_W-1:0];
            r_div_q   <= {r_div_q[mvts_pkg::PULSE_W-2:0], rem_ge};
            r_div_cnt <= r_div_cnt + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_o_pulse  <= r_pulse;
            r_o_power  <= r_power;
            r_o_active <= r_active;
            r_o_rv     <= r_rep_valid;
            r_o_rk     <= r_rep_kind;
            r_o_rtds   <= r_rep_tds;
            if (angle_zero) begin
                r_o_angle <= '0;
            end else if (r_div_q > mvts_pkg::MAX_ANGLE) begin
                r_o_angle <= mvts_pkg::ANGLE_W'(mvts_pkg::MAX_ANGLE);
            end else begin
                r_o_angle <= r_div_q[mvts_pkg::ANGLE_W-1:0];
            end
        end
    end

    assign o_pulse_width    = r_o_pulse;
    assign o_power_on       = r_o_power;
    assign o_adjusting      = r_o_active;
    assign o_report_valid   = r_o_rv;
    assign o_report_kind    = r_o_rk;
    assign o_report_tds     = r_o_rtds;
    assign o_steering_angle = r_o_angle;

endmodule

### hw/rtl/mixing_valve_tds_stepper.sv
// ----------------------------------------------------------------------------
// mixing_valve_tds_stepper
// Dead-band stepping regulator for a servo mixing valve.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one command word: tick with sample, outlet event, restart
//   adjust or start of a raw measurement (command code in tuser).
//   m_axis returns exactly one result word per command word: pulse width,
//   power and adjusting state, an optional quality report and the angle.
//   cfg port writes target, tolerance and pulse limits; the user must write
//   them only while the block is idle, which the block does not enforce.
// sequence
//   a word passes update and reciprocal scaling, then the bit-serial angle
//   divider, before m_axis tvalid; one word is in flight at a time, so the
//   next word is accepted only once the last result is loaded for output.
// reset
//   synchronous active-low reset loads the default limits, pulse at its
//   maximum, no outlet open, adjusting on, raw mode off, power off.
// stall
//   a result waits in the output register; the next word is accepted
//   meanwhile and its result is held until the waiting one is taken.
// ----------------------------------------------------------------------------
module mixing_valve_tds_stepper #(
    parameter int NUM_OUTLETS  = mvts_pkg::NUM_OUTLETS_DEF,
    parameter int SETTLE_TICKS = mvts_pkg::SETTLE_TICKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wen,
    input  logic [mvts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mvts_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tds_sample[11:0], outlet_id[14:12], outlet_open[15]
    input  logic [mvts_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // cmd[1:0]
    input  logic [mvts_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pulse_width[11:0], power_on[12], adjusting[13], report_tds[25:14],
    // steering_angle[32:26], zero[39:33]
    output logic [mvts_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // report_valid[0], report_kind[1]
    output logic [mvts_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

    mvts_pkg::t_dp_cmd  dp_cmd;
    mvts_pkg::t_dp_stat dp_stat;

    logic [mvts_pkg::PULSE_W-1:0] pulse_width;
    logic                         power_on;
    logic                         adjusting;
    logic                         report_valid;
    logic                         report_kind;
    logic [mvts_pkg::TDS_W-1:0]   report_tds;
    logic [mvts_pkg::ANGLE_W-1:0] steering_angle;

    mvts_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (dp_cmd),
        .i_stat    (dp_stat)
    );

    mvts_dp #(
        .NUM_OUTLETS  (NUM_OUTLETS),
        .SETTLE_TICKS (SETTLE_TICKS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_cfg_wen        (i_cfg_wen),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_cmd         (s_axis_tuser),
        .i_tds_sample     (s_axis_tdata[11:0]),
        .i_outlet_id      (s_axis_tdata[14:12]),
        .i_outlet_open    (s_axis_tdata[15]),
        .o_pulse_width    (pulse_width),
        .o_power_on       (power_on),
        .o_adjusting      (adjusting),
        .o_report_valid   (report_valid),
        .o_report_kind    (report_kind),
        .o_report_tds     (report_tds),
        .o_steering_angle (steering_angle)
    );

    assign m_axis_tdata = {7'b0000000, steering_angle, report_tds, adjusting, power_on,
                           pulse_width};
    assign m_axis_tuser = {report_kind, report_valid};

endmodule

### hw/rtl/mvts_checker.sv
// ----------------------------------------------------------------------------
// mvts_checker
// Port-level checks of the stepper, bound to the top level.
// ----------------------------------------------------------------------------
module mvts_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mvts_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic [mvts_pkg::M_TUSER_W-1:0]  m_axis_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // one word in flight at a time
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("word accepted while another is in work");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[32:26] <= 7'd90)
        else $error("steering angle above 90");

    // no report kind or value without a report
    a_no_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> !m_axis_tuser[1]
        && m_axis_tdata[25:14] == 12'd0)
        else $error("report fields set without a report");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid after reset");

endmodule

bind mixing_valve_tds_stepper mvts_checker u_mvts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
